@@ sv/assert_macros.svh @@
// assertion macros shared by the scheduler rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge, quiet while reset is asserted
`define TFSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising clock edge, including during reset
`define TFSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/tfss_pkg.sv @@
// types, constants and codes for the telemetry frame slot scheduler
// no dependencies; used by tfss_frame_calc and the top level
package tfss_pkg;

  localparam int          LANE_COUNT  = 8;
  localparam int unsigned FRAME_BYTES = 32;
  localparam int unsigned PAYLOAD_MAX = 28;
  localparam int unsigned EYE_BYTES   = 768;
  localparam int unsigned TAP_COUNT   = 8;

  localparam int unsigned CHUNK_MAX    = PAYLOAD_MAX - 2;
  localparam int unsigned STATUS_LEN   = 6;
  localparam int unsigned COUNTERS_LEN = 16;
  localparam int unsigned META_LEN     = 3;
  localparam int unsigned CHUNK_HDR    = 2;

  localparam int EYE_POS_W = 16;
  localparam int SEQ_W     = 16;
  localparam int CNT_W     = 32;

  localparam logic ITEM_TICK  = 1'b0;
  localparam logic ITEM_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    PH_STATUS   = 2'd0,
    PH_COUNTERS = 2'd1,
    PH_TAPS     = 2'd2,
    PH_EYE      = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    FK_STATUS    = 3'd0,
    FK_COUNTERS  = 3'd1,
    FK_TAPS      = 3'd2,
    FK_EYE_META  = 3'd3,
    FK_EYE_CHUNK = 3'd4
  } frame_kind_e;

  // one lane's entry in the state memory
  typedef struct packed {
    phase_e                 phase;
    logic                   meta_done;
    logic [EYE_POS_W-1:0]   eye_pos;
    logic [SEQ_W-1:0]       seq;
    logic [CNT_W-1:0]       frames;
    logic [CNT_W-1:0]       deferrals;
  } lane_rec_t;

  localparam int LANE_REC_W = $bits(lane_rec_t);

  typedef struct packed {
    logic        emitted;
    logic        held_back;
    frame_kind_e frame_kind;
    logic [15:0] sequence_res;
    logic [4:0]  payload_length;
    logic [9:0]  chunk_offset;
    logic [4:0]  chunk_length;
  } calc_res_t;

endpackage

@@ sv/tfss_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; holds the per-lane scheduler records
module tfss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tfss_frame_calc.sv @@
// slot rotation and eye chunking for one item against one lane record
// depends on tfss_pkg
module tfss_frame_calc (
  input  logic                kind_i,
  input  logic [9:0]          fifo_free_i,
  input  tfss_pkg::lane_rec_t rec_i,
  output tfss_pkg::lane_rec_t rec_o,
  output tfss_pkg::calc_res_t res_o
);

  localparam int PosW = tfss_pkg::EYE_POS_W + 1;

  logic [PosW-1:0] eye_total;
  logic [PosW-1:0] chunk_cap;
  logic [PosW-1:0] pos_ext;
  logic [PosW-1:0] left;
  logic [PosW-1:0] clen;
  logic [PosW-1:0] pos_next;
  logic            room_ok;

  assign eye_total = PosW'(tfss_pkg::EYE_BYTES);
  assign chunk_cap = PosW'(tfss_pkg::CHUNK_MAX);
  assign pos_ext   = PosW'(rec_i.eye_pos);
  assign left      = (pos_ext < eye_total) ? (eye_total - pos_ext) : '0;
  assign clen      = (left < chunk_cap) ? left : chunk_cap;
  assign pos_next  = pos_ext + clen;
  assign room_ok   = fifo_free_i >= 10'(tfss_pkg::FRAME_BYTES);

  always_comb begin
    rec_o = rec_i;
    res_o = '0;
    if (kind_i == tfss_pkg::ITEM_CLEAR) begin
      rec_o = '0;
    end else if (!room_ok) begin
      rec_o.deferrals = rec_i.deferrals + 1'b1;
      res_o.held_back = 1'b1;
    end else begin
      res_o.emitted      = 1'b1;
      res_o.sequence_res = rec_i.seq;
      rec_o.seq          = rec_i.seq + 1'b1;
      rec_o.frames       = rec_i.frames + 1'b1;
      case (rec_i.phase)
        tfss_pkg::PH_STATUS: begin
          res_o.frame_kind     = tfss_pkg::FK_STATUS;
          res_o.payload_length = 5'(tfss_pkg::STATUS_LEN);
          rec_o.phase          = tfss_pkg::PH_COUNTERS;
        end
        tfss_pkg::PH_COUNTERS: begin
          res_o.frame_kind     = tfss_pkg::FK_COUNTERS;
          res_o.payload_length = 5'(tfss_pkg::COUNTERS_LEN);
          rec_o.phase          = tfss_pkg::PH_TAPS;
        end
        tfss_pkg::PH_TAPS: begin
          res_o.frame_kind     = tfss_pkg::FK_TAPS;
          res_o.payload_length = 5'(tfss_pkg::TAP_COUNT);
          rec_o.phase          = tfss_pkg::PH_EYE;
        end
        default: begin
          if (!rec_i.meta_done) begin
            res_o.frame_kind     = tfss_pkg::FK_EYE_META;
            res_o.payload_length = 5'(tfss_pkg::META_LEN);
            rec_o.meta_done      = 1'b1;
          end else begin
            res_o.frame_kind     = tfss_pkg::FK_EYE_CHUNK;
            res_o.chunk_offset   = rec_i.eye_pos[9:0];
            res_o.chunk_length   = clen[4:0];
            res_o.payload_length = 5'(clen + PosW'(tfss_pkg::CHUNK_HDR));
            // whole eye gone: back to the status slot
            if (pos_next >= eye_total) begin
              rec_o.eye_pos   = '0;
              rec_o.meta_done = 1'b0;
              rec_o.phase     = tfss_pkg::PH_STATUS;
            end else begin
              rec_o.eye_pos = pos_next[tfss_pkg::EYE_POS_W-1:0];
            end
          end
        end
      endcase
    end
  end

endmodule

@@ sv/telemetry_frame_slot_scheduler.sv @@
// channel   direction  handshake                 payload
// input     in         in_valid_i / in_stall_o   kind_i, lane_i, fifo_free_i
// result    out        out_valid_o / out_stall_i emitted_o .. deferrals_total_o
//
// one item per cycle sustained while the result side does not stall; a result passes
// the ram read, then a read-modify-write into the output register
// a write and a read of the same lane in one cycle are bridged by a forward register
// reset clears per-lane valid bits at once; an unwritten lane reads as zero, no sweep
// a stalled result holds the output register and then the item waiting in the read stage
//
// top level of the scheduler: state ram, frame calculation and bus totals
// depends on tfss_pkg, tfss_ram, tfss_frame_calc and assert_macros.svh
`include "assert_macros.svh"

module telemetry_frame_slot_scheduler #(
  parameter int LANE_COUNT = tfss_pkg::LANE_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [2:0]  lane_i,
  input  logic [9:0]  fifo_free_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        emitted_o,
  output logic        held_back_o,
  output logic [2:0]  frame_kind_o,
  output logic [15:0] sequence_res_o,
  output logic [4:0]  payload_length_o,
  output logic [9:0]  chunk_offset_o,
  output logic [4:0]  chunk_length_o,
  output logic [31:0] frames_total_o,
  output logic [31:0] deferrals_total_o
);

  localparam int LaneW = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;

  logic                        in_xfer;
  logic                        s1_go;
  logic [LaneW-1:0]            lane_eff;
  logic                        ram_we;
  logic [tfss_pkg::LANE_REC_W-1:0] ram_rdata;

  logic                        s1_valid_q;
  logic                        s1_kind_q;
  logic [LaneW-1:0]            s1_lane_q;
  logic [9:0]                  s1_free_q;
  logic                        rd_vld_q;
  logic                        fwd_hit_q;
  tfss_pkg::lane_rec_t         fwd_rec_q;
  logic [LANE_COUNT-1:0]       lane_vld_q;

  tfss_pkg::lane_rec_t         rec_cur;
  tfss_pkg::lane_rec_t         rec_new;
  tfss_pkg::calc_res_t         res;

  logic [31:0]                 frames_q, frames_d;
  logic [31:0]                 defers_q, defers_d;

  logic                        out_valid_q;
  tfss_pkg::calc_res_t         out_res_q;
  logic [31:0]                 out_frames_q;
  logic [31:0]                 out_defers_q;

  // lanes beyond the configured count are served as lane zero
  assign lane_eff = (32'(lane_i) < LANE_COUNT) ? LaneW'(lane_i) : '0;

  assign s1_go      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign ram_we     = s1_go;

  tfss_ram #(
    .WIDTH (tfss_pkg::LANE_REC_W),
    .DEPTH (LANE_COUNT)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_lane_q),
    .wdata_i (rec_new),
    .re_i    (in_xfer),
    .raddr_i (lane_eff),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (fwd_hit_q) begin
      rec_cur = fwd_rec_q;
    end else if (rd_vld_q) begin
      rec_cur = tfss_pkg::lane_rec_t'(ram_rdata);
    end else begin
      rec_cur = '0;
    end
  end

  tfss_frame_calc u_calc (
    .kind_i      (s1_kind_q),
    .fifo_free_i (s1_free_q),
    .rec_i       (rec_cur),
    .rec_o       (rec_new),
    .res_o       (res)
  );

  // bus totals are sums over lanes, so a clear takes the lane's counts back out
  always_comb begin
    frames_d = frames_q;
    defers_d = defers_q;
    if (s1_kind_q == tfss_pkg::ITEM_CLEAR) begin
      frames_d = frames_q - rec_cur.frames;
      defers_d = defers_q - rec_cur.deferrals;
    end else if (res.emitted) begin
      frames_d = frames_q + 1'b1;
    end else if (res.held_back) begin
      defers_d = defers_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      fwd_hit_q   <= 1'b0;
      lane_vld_q  <= '0;
      frames_q    <= '0;
      defers_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
        rd_vld_q   <= lane_vld_q[lane_eff];
        // same lane written this cycle: the ram read sees the old entry
        fwd_hit_q  <= ram_we && (s1_lane_q == lane_eff);
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
        fwd_hit_q  <= 1'b0;
      end
      if (ram_we) begin
        lane_vld_q[s1_lane_q] <= 1'b1;
      end
      if (s1_go) begin
        frames_q    <= frames_d;
        defers_q    <= defers_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_kind_q <= kind_i;
      s1_lane_q <= lane_eff;
      s1_free_q <= fifo_free_i;
      fwd_rec_q <= rec_new;
    end
    if (s1_go) begin
      out_res_q    <= res;
      out_frames_q <= frames_d;
      out_defers_q <= defers_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign emitted_o         = out_res_q.emitted;
  assign held_back_o       = out_res_q.held_back;
  assign frame_kind_o      = out_res_q.frame_kind;
  assign sequence_res_o    = out_res_q.sequence_res;
  assign payload_length_o  = out_res_q.payload_length;
  assign chunk_offset_o    = out_res_q.chunk_offset;
  assign chunk_length_o    = out_res_q.chunk_length;
  assign frames_total_o    = out_frames_q;
  assign deferrals_total_o = out_defers_q;

  `TFSS_ASSERT(a_fwd_needs_item, fwd_hit_q |-> s1_valid_q, "forward hit with empty read stage")
  `TFSS_ASSERT(a_emit_xor_defer, out_valid_q |-> !(emitted_o && held_back_o), "emitted and held back")
  `TFSS_ASSERT(a_frame_total_step, (s1_go && res.emitted) |=> (frames_q == $past(frames_q) + 32'd1), "frame total did not step")
  `TFSS_ASSERT(a_chunk_only_eye, (out_valid_q && frame_kind_o != tfss_pkg::FK_EYE_CHUNK) |-> (chunk_length_o == 5'd0), "chunk length on non-chunk frame")
  `TFSS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for telemetry_frame_slot_scheduler: directed and random
// lane ticks and clears against a per-lane slot predictor, with bursty input and stalls
// depends on tfss_pkg and the scheduler rtl
module testbench;

  localparam int RANDOM_ITEMS  = 1400;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int REPORT_LIMIT  = 10;
  localparam int HOLD_CYCLES   = 300;

  localparam logic [1:0] RX_OPEN     = 2'd0;
  localparam logic [1:0] RX_LIGHT    = 2'd1;
  localparam logic [1:0] RX_HEAVY    = 2'd2;
  localparam logic [1:0] RX_PERIODIC = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [2:0] lane;
    logic [9:0] room;
  } lane_item_t;

  typedef struct packed {
    logic                  emitted;
    logic                  held_back;
    tfss_pkg::frame_kind_e fkind;
    logic [15:0]           seq;
    logic [4:0]            plen;
    logic [9:0]            coff;
    logic [4:0]            clen;
    logic [31:0]           frames;
    logic [31:0]           defers;
  } frame_desc_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic        kind = tfss_pkg::ITEM_TICK;
  logic [2:0]  lane = 3'd0;
  logic [9:0]  fifo_free = 10'd0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic        emitted_o;
  logic        held_back_o;
  logic [2:0]  frame_kind_o;
  logic [15:0] sequence_res_o;
  logic [4:0]  payload_length_o;
  logic [9:0]  chunk_offset_o;
  logic [4:0]  chunk_length_o;
  logic [31:0] frames_total_o;
  logic [31:0] deferrals_total_o;

  telemetry_frame_slot_scheduler dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind),
    .lane_i            (lane),
    .fifo_free_i       (fifo_free),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .emitted_o         (emitted_o),
    .held_back_o       (held_back_o),
    .frame_kind_o      (frame_kind_o),
    .sequence_res_o    (sequence_res_o),
    .payload_length_o  (payload_length_o),
    .chunk_offset_o    (chunk_offset_o),
    .chunk_length_o    (chunk_length_o),
    .frames_total_o    (frames_total_o),
    .deferrals_total_o (deferrals_total_o)
  );

  always #2 clk_i = ~clk_i;

  // predicted per-lane slot state
  tfss_pkg::phase_e lane_phase   [tfss_pkg::LANE_COUNT];
  logic             eye_meta_done[tfss_pkg::LANE_COUNT];
  int unsigned      eye_next     [tfss_pkg::LANE_COUNT];
  logic [15:0]      lane_seq     [tfss_pkg::LANE_COUNT];
  logic [31:0]      lane_frames  [tfss_pkg::LANE_COUNT];
  logic [31:0]      lane_defers  [tfss_pkg::LANE_COUNT];
  logic [31:0]      bus_frames = '0;
  logic [31:0]      bus_defers = '0;

  lane_item_t  pending_items[$];
  frame_desc_t frame_expect_q[$];
  int          total_items = 0;
  int          items_taken = 0;
  int          mismatches = 0;
  logic        in_xfer = 1'b0;

  initial begin
    for (int i = 0; i < tfss_pkg::LANE_COUNT; i++) begin
      lane_phase[i]    = tfss_pkg::PH_STATUS;
      eye_meta_done[i] = 1'b0;
      eye_next[i]      = 0;
      lane_seq[i]      = '0;
      lane_frames[i]   = '0;
      lane_defers[i]   = '0;
    end
  end

  function automatic frame_desc_t schedule_frame(logic item_kind, logic [2:0] lane_sel,
                                                  logic [9:0] room);
    frame_desc_t d;
    int unsigned ln;
    int unsigned left;
    int unsigned clen;
    d = '0;
    ln = lane_sel;
    if (ln >= tfss_pkg::LANE_COUNT) ln = 0;
    if (item_kind == tfss_pkg::ITEM_CLEAR) begin
      // totals are sums over lanes, so the lane's share leaves them
      bus_frames        = bus_frames - lane_frames[ln];
      bus_defers        = bus_defers - lane_defers[ln];
      lane_frames[ln]   = '0;
      lane_defers[ln]   = '0;
      lane_phase[ln]    = tfss_pkg::PH_STATUS;
      eye_meta_done[ln] = 1'b0;
      eye_next[ln]      = 0;
      lane_seq[ln]      = '0;
    end else if (room < tfss_pkg::FRAME_BYTES) begin
      lane_defers[ln] = lane_defers[ln] + 1;
      bus_defers      = bus_defers + 1;
      d.held_back     = 1'b1;
    end else begin
      d.emitted = 1'b1;
      d.seq     = lane_seq[ln];
      case (lane_phase[ln])
        tfss_pkg::PH_STATUS: begin
          d.fkind = tfss_pkg::FK_STATUS;
          d.plen  = 5'(tfss_pkg::STATUS_LEN);
          lane_phase[ln] = tfss_pkg::PH_COUNTERS;
        end
        tfss_pkg::PH_COUNTERS: begin
          d.fkind = tfss_pkg::FK_COUNTERS;
          d.plen  = 5'(tfss_pkg::COUNTERS_LEN);
          lane_phase[ln] = tfss_pkg::PH_TAPS;
        end
        tfss_pkg::PH_TAPS: begin
          d.fkind = tfss_pkg::FK_TAPS;
          d.plen  = 5'(tfss_pkg::TAP_COUNT);
          lane_phase[ln] = tfss_pkg::PH_EYE;
        end
        default: begin
          if (!eye_meta_done[ln]) begin
            d.fkind = tfss_pkg::FK_EYE_META;
            d.plen  = 5'(tfss_pkg::META_LEN);
            eye_meta_done[ln] = 1'b1;
          end else begin
            left = (eye_next[ln] < tfss_pkg::EYE_BYTES) ?
                   tfss_pkg::EYE_BYTES - eye_next[ln] : 0;
            clen = (left < tfss_pkg::CHUNK_MAX) ? left : tfss_pkg::CHUNK_MAX;
            d.fkind = tfss_pkg::FK_EYE_CHUNK;
            d.coff  = 10'(eye_next[ln]);
            d.clen  = 5'(clen);
            d.plen  = 5'(clen + tfss_pkg::CHUNK_HDR);
            eye_next[ln] = eye_next[ln] + clen;
            if (eye_next[ln] >= tfss_pkg::EYE_BYTES) begin
              eye_next[ln]      = 0;
              eye_meta_done[ln] = 1'b0;
              lane_phase[ln]    = tfss_pkg::PH_STATUS;
            end
          end
        end
      endcase
      lane_seq[ln]    = lane_seq[ln] + 1;
      lane_frames[ln] = lane_frames[ln] + 1;
      bus_frames      = bus_frames + 1;
    end
    d.frames = bus_frames;
    d.defers = bus_defers;
    return d;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    end
  endfunction

  function automatic void add_item(logic item_kind, logic [2:0] lane_sel, logic [9:0] room);
    lane_item_t it;
    it.kind = item_kind;
    it.lane = lane_sel;
    it.room = room;
    pending_items.push_back(it);
  endfunction

  // acceptance, prediction and result checking at the rising edge
  always @(posedge clk_i) begin
    frame_desc_t want;
    in_xfer <= rst_ni && in_valid && !in_stall_o;
    if (rst_ni && in_valid && !in_stall_o) begin
      frame_expect_q.push_back(schedule_frame(kind, lane, fifo_free));
      items_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall) begin
      if (frame_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result transfer with nothing expected", $realtime);
      end else begin
        want = frame_expect_q.pop_front();
        check_field("emitted", want.emitted, emitted_o);
        check_field("held_back", want.held_back, held_back_o);
        check_field("frame_kind", want.fkind, frame_kind_o);
        check_field("sequence_res", want.seq, sequence_res_o);
        check_field("payload_length", want.plen, payload_length_o);
        check_field("chunk_offset", want.coff, chunk_offset_o);
        check_field("chunk_length", want.clen, chunk_length_o);
        check_field("frames_total", want.frames, frames_total_o);
        check_field("deferrals_total", want.defers, deferrals_total_o);
      end
    end
  end

  // sender: bursts of random length with random gaps
  int gap_left = 0;
  int burst_left = 0;

  always @(negedge clk_i) begin
    lane_item_t it;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_xfer) begin
      // payload holds until the transfer happens
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_items.size() != 0) begin
      it = pending_items.pop_front();
      kind      <= it.kind;
      lane      <= it.lane;
      fifo_free <= it.room;
      in_valid  <= 1'b1;
      if (burst_left != 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: the stall pattern is redrawn at random periodically, plus long hold-offs
  int         rx_cycle = 0;
  int         hold_left = 0;
  logic [1:0] rx_mode = RX_OPEN;

  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle == 600 || rx_cycle == 2600) hold_left = HOLD_CYCLES;
    if (rx_cycle % 200 == 0) rx_mode = 2'($urandom_range(0, 3));
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_stall <= 1'b0;
        RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 6);
        default:   out_stall <= ((rx_cycle % 8) < 3);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("telemetry_frame_slot_scheduler test failed");
      $finish;
    end
  end

  initial begin
    logic [2:0] cur_lane;
    logic [9:0] room;
    cur_lane = 3'd0;

    // walk lane 0 through status, counters, taps, eye metadata and two chunks,
    // with deferrals at the room boundary
    add_item(tfss_pkg::ITEM_TICK, 3'd0, 10'd1023);
    add_item(tfss_pkg::ITEM_TICK, 3'd0, 10'd32);
    add_item(tfss_pkg::ITEM_TICK, 3'd0, 10'd31);
    add_item(tfss_pkg::ITEM_TICK, 3'd0, 10'd0);
    add_item(tfss_pkg::ITEM_TICK, 3'd0, 10'd512);
    add_item(tfss_pkg::ITEM_TICK, 3'd0, 10'd1023);
    add_item(tfss_pkg::ITEM_TICK, 3'd0, 10'd33);
    add_item(tfss_pkg::ITEM_TICK, 3'd0, 10'd1023);
    add_item(tfss_pkg::ITEM_TICK, 3'd7, 10'd1023);
    add_item(tfss_pkg::ITEM_TICK, 3'd7, 10'h2AA);
    add_item(tfss_pkg::ITEM_TICK, 3'd7, 10'h155);
    // lane clear drops the lane's counts out of the totals
    add_item(tfss_pkg::ITEM_CLEAR, 3'd0, 10'd1023);
    add_item(tfss_pkg::ITEM_TICK, 3'd0, 10'd1023);
    add_item(tfss_pkg::ITEM_CLEAR, 3'd5, 10'd0);
    add_item(tfss_pkg::ITEM_CLEAR, 3'd7, 10'd700);
    add_item(tfss_pkg::ITEM_CLEAR, 3'd7, 10'd700);
    add_item(tfss_pkg::ITEM_TICK, 3'd7, 10'd31);
    add_item(tfss_pkg::ITEM_TICK, 3'd3, 10'd1023);

    // random part: mostly ticks with room so lanes run deep into the eye,
    // lane runs on one lane exercise back-to-back updates of the same entry
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 1) == 0) cur_lane = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 19))
        0, 1, 2: room = 10'($urandom_range(0, tfss_pkg::FRAME_BYTES - 1));
        3:       room = 10'd1023;
        4:       room = 10'(tfss_pkg::FRAME_BYTES);
        default: room = 10'($urandom_range(tfss_pkg::FRAME_BYTES, 1023));
      endcase
      if ($urandom_range(0, 149) == 0) add_item(tfss_pkg::ITEM_CLEAR, cur_lane, room);
      else add_item(tfss_pkg::ITEM_TICK, cur_lane, room);
    end
    total_items = pending_items.size();

    // falling reset edge before the first clock so the async reset takes hold
    #1 rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (items_taken < total_items) @(posedge clk_i);
    while (frame_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("telemetry_frame_slot_scheduler test passed");
    end else begin
      $display("telemetry_frame_slot_scheduler test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/tfss_pkg.sv
sv/tfss_ram.sv
sv/tfss_frame_calc.sv
sv/telemetry_frame_slot_scheduler.sv
sim/testbench.sv
